[hdl/led_blink_controller_top_assert.svh]
// Assertion macros used by the LED blink controller checker.
// No dependencies; take in with a bare `include.
`ifndef LED_BLINK_CONTROLLER_TOP_ASSERT_SVH
`define LED_BLINK_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lbc_pkg.sv]
// Types and constants of the LED blink controller.
// No dependencies; used by lbc_step, lbc_out_reg and the top level.
`default_nettype none

package lbc_pkg;

	// Command kinds carried in the kind field
	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_OFF     = 3'd1;
	localparam logic [2:0] KIND_ON      = 3'd2;
	localparam logic [2:0] KIND_TIMED   = 3'd3;
	localparam logic [2:0] KIND_ENDLESS = 3'd4;
	localparam logic [2:0] KIND_ASYM    = 3'd5;

	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_ON      = 3'd1,
		MODE_TIMED   = 3'd2,
		MODE_ENDLESS = 3'd3,
		MODE_ASYM    = 3'd4
	} mode_t;

	localparam logic [15:0] DEFAULT_TIME = 16'd600;
	localparam logic [15:0] MIN_TIME     = 16'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] time_a;
		logic [15:0] time_b;
		logic [15:0] now;
	} cmd_t;

	typedef struct packed {
		logic led_level;
		logic busy_res;
	} res_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] remaining_ms;
		logic [15:0] lit_time;
		logic [15:0] dark_time;
		logic [15:0] last_toggle;
		logic        level;
	} state_t;

	localparam state_t STATE_RST = '{
		mode:         MODE_OFF,
		remaining_ms: 16'd0,
		lit_time:     DEFAULT_TIME,
		dark_time:    DEFAULT_TIME,
		last_toggle:  16'd0,
		level:        1'b0
	};

endpackage

`default_nettype wire

[hdl/lbc_stream_if.sv]
// Valid/ready stream interface used for the command and result channels.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface lbc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/lbc_step.sv]
// Next-state and result logic for one command of the LED blink controller.
// Depends on lbc_pkg.
`default_nettype none

module lbc_step #(
	parameter int unsigned TICK_STEP = 10
) (
	input  wire lbc_pkg::state_t st,
	input  wire lbc_pkg::cmd_t   cmd,
	output lbc_pkg::state_t      nxt,
	output lbc_pkg::res_t        res
);

	localparam logic [15:0] STEP = 16'(TICK_STEP);

	logic        chk_toggle;
	logic [15:0] threshold;
	logic [15:0] elapsed;

	// Threshold follows the level held before the tick
	assign threshold = st.level ? st.lit_time : st.dark_time;
	assign elapsed   = cmd.now - st.last_toggle;

	always_comb begin
		nxt        = st;
		chk_toggle = 1'b0;
		unique case (cmd.kind)
			lbc_pkg::KIND_TICK: begin
				unique case (st.mode)
					lbc_pkg::MODE_OFF: nxt.level = 1'b0;
					lbc_pkg::MODE_ON:  nxt.level = 1'b1;
					lbc_pkg::MODE_TIMED: begin
						if (st.remaining_ms > STEP) begin
							nxt.remaining_ms = st.remaining_ms - STEP;
							chk_toggle       = 1'b1;
						end else begin
							nxt.remaining_ms = 16'd0;
							nxt.mode         = lbc_pkg::MODE_OFF;
							nxt.level        = 1'b0;
						end
					end
					lbc_pkg::MODE_ENDLESS, lbc_pkg::MODE_ASYM: chk_toggle = 1'b1;
					default: chk_toggle = 1'b0;
				endcase
				if (chk_toggle && (elapsed >= threshold)) begin
					nxt.last_toggle = cmd.now;
					nxt.level       = ~st.level;
				end
			end
			lbc_pkg::KIND_OFF: begin
				nxt.mode         = lbc_pkg::MODE_OFF;
				nxt.remaining_ms = 16'd0;
				nxt.level        = 1'b0;
			end
			lbc_pkg::KIND_ON: begin
				nxt.mode  = lbc_pkg::MODE_ON;
				nxt.level = 1'b1;
			end
			lbc_pkg::KIND_TIMED: begin
				nxt.mode         = lbc_pkg::MODE_TIMED;
				nxt.remaining_ms = cmd.time_a;
				nxt.lit_time     = cmd.time_b;
				nxt.dark_time    = cmd.time_b;
				nxt.last_toggle  = cmd.now;
				nxt.level        = 1'b1;
			end
			lbc_pkg::KIND_ENDLESS: begin
				nxt.mode         = lbc_pkg::MODE_ENDLESS;
				nxt.remaining_ms = 16'd0;
				nxt.lit_time     = cmd.time_a;
				nxt.dark_time    = cmd.time_a;
				nxt.last_toggle  = cmd.now;
				nxt.level        = 1'b1;
			end
			lbc_pkg::KIND_ASYM: begin
				// raise zero times to the minimum
				nxt.mode         = lbc_pkg::MODE_ASYM;
				nxt.remaining_ms = 16'd0;
				nxt.lit_time     = (cmd.time_a == 16'd0) ? lbc_pkg::MIN_TIME : cmd.time_a;
				nxt.dark_time    = (cmd.time_b == 16'd0) ? lbc_pkg::MIN_TIME : cmd.time_b;
				nxt.last_toggle  = cmd.now;
				nxt.level        = 1'b1;
			end
			default: nxt = st;
		endcase
	end

	assign res.led_level = nxt.level;
	assign res.busy_res  = (nxt.mode == lbc_pkg::MODE_TIMED) && (nxt.remaining_ms != 16'd0);

endmodule

`default_nettype wire

[hdl/lbc_out_reg.sv]
// Result register with valid/ready handshake on the output channel.
// Depends on lbc_pkg and lbc_stream_if.
`default_nettype none

module lbc_out_reg (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           load,
	input  wire lbc_pkg::res_t res_d,
	output logic          free,
	lbc_stream_if.source  res
);

	logic          valid_q;
	lbc_pkg::res_t data_q;

	// Register can take a new result when empty or draining this cycle
	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= res_d;
		end
	end

	assign res.valid = valid_q;
	assign res.data  = data_q;

endmodule

`default_nettype wire

[hdl/led_blink_controller_top.sv]
// Top level of the LED blink controller: input register, state and result stage.
// Depends on lbc_pkg, lbc_stream_if, lbc_step and lbc_out_reg.
`default_nettype none

// Each command transfer on cmd (tick, off, on, timed, endless or asymmetric
// blink, with two millisecond operands and the current 16-bit timestamp)
// yields exactly one result transfer on res carrying the LED level and the
// busy flag of a running timed blink. A command is taken into the input
// register, processed there against the controller state, and its result
// lands in the output register when that register is free; a stalled result
// holds the next command in the input register. One command is taken every
// clock cycle while res is ready; the state update is a single compare,
// subtract and select between the input register and the state/result
// registers. While a result waits, one further command is still taken into
// the input register. TICK_STEP sets how many milliseconds each tick removes
// from a timed blink's remaining time.
module led_blink_controller_top #(
	parameter int unsigned TICK_STEP = 10
) (
	input  wire         clk,
	input  wire         arst_n,
	lbc_stream_if.sink   cmd,
	lbc_stream_if.source res
);

	// input register stage
	logic            valid_s1;
	lbc_pkg::cmd_t   cmd_s1;

	// controller state
	lbc_pkg::state_t state_q;
	lbc_pkg::state_t state_nxt;
	lbc_pkg::res_t   res_nxt;

	logic out_free;
	logic advance;

	// Advance the held command once the result register can take it
	assign advance   = valid_s1 && out_free;
	// Take a new command when the input register is empty or moving on
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Hold the payload until it advances
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	lbc_step #(
		.TICK_STEP (TICK_STEP)
	) u_step (
		.st  (state_q),
		.cmd (cmd_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// Commit the new state in the same cycle the result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbc_pkg::STATE_RST;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	lbc_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res_d  (res_nxt),
		.free   (out_free),
		.res    (res)
	);

endmodule

`default_nettype wire

[hdl/lbc_checker.sv]
// Port-level checker for the LED blink controller, bound to the top level.
// Depends on led_blink_controller_top_assert.svh.
`default_nettype none

`include "led_blink_controller_top_assert.svh"

module lbc_checker (
	input wire clk,
	input wire arst_n,
	input wire cmd_valid,
	input wire cmd_ready,
	input wire res_valid,
	input wire res_ready,
	input wire led_level,
	input wire busy_res
);

	// a stalled result holds
	`LBC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(led_level) && $stable(busy_res), "result changed while stalled")

	// an empty result register never back-pressures commands
	`LBC_ASSERT_NOW(a_cmd_ready, clk, arst_n, !res_valid, cmd_ready, "command stalled with no result pending")

	// a fresh result follows a command transfer through the input and result registers
	`LBC_ASSERT_NOW(a_res_src, clk, arst_n, $rose(res_valid), $past(cmd_valid && cmd_ready, 2), "result without a matching command")

endmodule

bind led_blink_controller_top lbc_checker u_lbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.led_level (res.data.led_level),
	.busy_res  (res.data.busy_res)
);

`default_nettype wire
